// ===== sv/twg_pkg.sv =====
// ----------------------------------------------------------------------------
// twg_pkg
// Shared types and constants of the touch wake gesture detector.
// ----------------------------------------------------------------------------
package twg_pkg;

  typedef logic signed [15:0] coord_t;

  // event kinds
  typedef enum logic [2:0] {
    FN_POS_X    = 3'd0,
    FN_POS_Y    = 3'd1,
    FN_TRACK_ID = 3'd2,
    FN_SLOT     = 3'd3,
    FN_OTHER    = 3'd4
  } func_t;

  // configuration register indexes
  localparam logic [2:0] REG_EN_DOUBLE_TAP = 3'd0;
  localparam logic [2:0] REG_EN_RIGHT      = 3'd1;
  localparam logic [2:0] REG_EN_LEFT       = 3'd2;
  localparam logic [2:0] REG_EN_UP         = 3'd3;
  localparam logic [2:0] REG_EN_DOWN       = 3'd4;
  localparam logic [2:0] REG_SWIPE_TIMEOUT = 3'd5;
  localparam logic [2:0] REG_TAP_WINDOW    = 3'd6;
  localparam logic [2:0] REG_TAP_RADIUS    = 3'd7;

  typedef enum logic [1:0] {
    HG_NONE  = 2'd0,
    HG_RIGHT = 2'd1,
    HG_LEFT  = 2'd2
  } hgest_t;

  typedef enum logic [1:0] {
    VG_NONE = 2'd0,
    VG_UP   = 2'd1,
    VG_DOWN = 2'd2
  } vgest_t;

  localparam coord_t BAND_1      = 16'sd340;
  localparam coord_t BAND_2      = 16'sd620;
  localparam coord_t VERT_SPLIT  = 16'sd800;
  localparam coord_t HORIZ_SPLIT = 16'sd540;
  localparam coord_t FINAL_GAP   = 16'sd270;
  localparam int     VERT_STEP   = 135;
  localparam int     OFF_X_SHIFT = 5000;

  localparam logic [15:0] SWIPE_TIMEOUT_RST = 16'd300;
  localparam logic [15:0] TAP_WINDOW_RST    = 16'd500;
  localparam logic [11:0] TAP_RADIUS_RST    = 12'd150;

  // swipe tracker control
  typedef struct packed {
    logic step;   // request moves through the result stage
    logic clear;  // slot, release or screen-on touch outside the bottom edge
    logic eval;   // position complete, run the tracker
    logic off;    // screen off
  } swipe_ctl_t;

  // double tap tracker control
  typedef struct packed {
    logic step;
    logic clear;    // slot event
    logic lift;     // finger release
    logic check;    // release with screen off and double tap enabled
  } tap_ctl_t;

endpackage

// ===== sv/twg_horiz.sv =====
// ----------------------------------------------------------------------------
// twg_horiz
// Horizontal swipe tracker: start point, two barrier bands, timeout.
// ----------------------------------------------------------------------------
module twg_horiz import twg_pkg::*; #(
  parameter int SCREEN_WIDTH = 1080
) (
  input  logic        clk,
  input  logic        rst,
  input  swipe_ctl_t  ctl,
  input  coord_t      x,
  input  logic [31:0] now,
  input  logic        en_right,
  input  logic        en_left,
  input  logic [15:0] timeout,
  output hgest_t      res
);

  localparam coord_t RIGHT_END = 16'(SCREEN_WIDTH - 270);

  coord_t      start_x, start_x_next, sx;
  logic [31:0] start_time, start_time_next, st;
  logic        armed, armed_next;
  logic [1:0]  bands, bands_next;
  logic        timely;

  always_comb begin
    sx = (start_x == 16'sd0) ? x : start_x;
    st = (start_x == 16'sd0) ? now : start_time;
    timely = (now - st) < {16'd0, timeout};
    start_x_next = start_x;
    start_time_next = start_time;
    armed_next = armed;
    bands_next = bands;
    res = HG_NONE;
    if (ctl.clear) begin
      start_x_next = '0;
      start_time_next = '0;
      armed_next = 1'b1;
      bands_next = '0;
    end else if (ctl.eval) begin
      start_x_next = sx;
      start_time_next = st;
      if (sx < HORIZ_SPLIT && ctl.off && en_right) begin
        if (bands[0] || (x > 16'sd0 && x < BAND_1)) begin
          bands_next[0] = 1'b1;
          if (bands[1] || (x > BAND_1 && x < BAND_2)) begin
            bands_next[1] = 1'b1;
            if (x > BAND_2 && x > RIGHT_END && armed && timely) begin
              res = HG_RIGHT;
              armed_next = 1'b0;
            end
          end
        end
      end else if (sx >= HORIZ_SPLIT && ctl.off && en_left) begin
        if (bands[0] || (x < RIGHT_END && x > BAND_2)) begin
          bands_next[0] = 1'b1;
          if (bands[1] || (x < BAND_2 && x > BAND_1)) begin
            bands_next[1] = 1'b1;
            if (x < BAND_1 && x < FINAL_GAP && armed && timely) begin
              res = HG_LEFT;
              armed_next = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_time <= '0;
      armed <= 1'b1;
      bands <= '0;
    end else if (ctl.step) begin
      start_x <= start_x_next;
      start_time <= start_time_next;
      armed <= armed_next;
      bands <= bands_next;
    end
  end

endmodule

// ===== sv/twg_vert.sv =====
// ----------------------------------------------------------------------------
// twg_vert
// Vertical swipe tracker: three 135-pixel steps from the start point.
// ----------------------------------------------------------------------------
module twg_vert import twg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  swipe_ctl_t  ctl,
  input  coord_t      y,
  input  logic [31:0] now,
  input  logic        en_up,
  input  logic        en_down,
  input  logic [15:0] timeout,
  output vgest_t      res
);

  localparam logic signed [17:0] STEP1 = 18'(VERT_STEP);
  localparam logic signed [17:0] STEP2 = 18'(2 * VERT_STEP);
  localparam logic signed [17:0] STEP3 = 18'(3 * VERT_STEP);

  coord_t             start_y, start_y_next, sy;
  logic [31:0]        start_time, start_time_next, st;
  logic               armed, armed_next;
  logic [1:0]         bands, bands_next;
  logic               timely;
  logic signed [17:0] s, yw;

  always_comb begin
    sy = (start_y == 16'sd0) ? y : start_y;
    st = (start_y == 16'sd0) ? now : start_time;
    timely = (now - st) < {16'd0, timeout};
    s = {{2{sy[15]}}, sy};
    yw = {{2{y[15]}}, y};
    start_y_next = start_y;
    start_time_next = start_time;
    armed_next = armed;
    bands_next = bands;
    res = VG_NONE;
    if (ctl.clear) begin
      start_y_next = '0;
      start_time_next = '0;
      armed_next = 1'b1;
      bands_next = '0;
    end else if (ctl.eval) begin
      start_y_next = sy;
      start_time_next = st;
      if (sy > VERT_SPLIT && en_up) begin
        if (bands[0] || (yw < s && yw > s - STEP1)) begin
          bands_next[0] = 1'b1;
          if (bands[1] || (yw < s - STEP1 && yw > s - STEP2)) begin
            bands_next[1] = 1'b1;
            if (yw < s - STEP3 && armed && timely) begin
              res = VG_UP;
              armed_next = 1'b0;
            end
          end
        end
      end else if (sy <= VERT_SPLIT && en_down) begin
        if (bands[0] || (yw > s && yw < s + STEP1)) begin
          bands_next[0] = 1'b1;
          if (bands[1] || (yw > s + STEP1 && yw < s + STEP2)) begin
            bands_next[1] = 1'b1;
            if (yw > s + STEP3 && armed && timely) begin
              res = VG_DOWN;
              armed_next = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_y <= '0;
      start_time <= '0;
      armed <= 1'b1;
      bands <= '0;
    end else if (ctl.step) begin
      start_y <= start_y_next;
      start_time <= start_time_next;
      armed <= armed_next;
      bands <= bands_next;
    end
  end

endmodule

// ===== sv/twg_tap.sv =====
// ----------------------------------------------------------------------------
// twg_tap
// Double tap tracker: edge margin, per-axis radius and tap window.
// ----------------------------------------------------------------------------
module twg_tap import twg_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1080,
  parameter int SCREEN_HEIGHT = 1920,
  parameter int EDGE_MARGIN   = 90
) (
  input  logic        clk,
  input  logic        rst,
  input  tap_ctl_t    ctl,
  input  coord_t      x,
  input  coord_t      y,
  input  logic [31:0] now,
  input  logic [15:0] window,
  input  logic [11:0] radius,
  output logic        hit
);

  localparam coord_t LO    = 16'(EDGE_MARGIN);
  localparam coord_t X_MAX = 16'(SCREEN_WIDTH - EDGE_MARGIN);
  localparam coord_t Y_MAX = 16'(SCREEN_HEIGHT - EDGE_MARGIN);

  logic [1:0]         count, count_next;
  logic [31:0]        tap_time, tap_time_next;
  coord_t             tap_x, tap_x_next, tap_y, tap_y_next;
  logic               armed, armed_next;
  logic               rel_seen, rel_seen_next, rel;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic               in_area, close;

  always_comb begin
    dx = {x[15], x} - {tap_x[15], tap_x};
    dy = {y[15], y} - {tap_y[15], tap_y};
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
    close = adx < {5'd0, radius} && ady < {5'd0, radius} &&
            (now - tap_time) < {16'd0, window};
    in_area = x >= LO && x <= X_MAX && y >= LO && y <= Y_MAX;
    rel = ctl.lift | rel_seen;
    count_next = count;
    tap_time_next = tap_time;
    tap_x_next = tap_x;
    tap_y_next = tap_y;
    armed_next = armed;
    rel_seen_next = rel;
    hit = 1'b0;
    if (ctl.clear) begin
      count_next = '0;
      tap_time_next = '0;
      tap_x_next = '0;
      tap_y_next = '0;
      armed_next = 1'b1;
    end else if (ctl.check && in_area && armed && rel) begin
      rel_seen_next = 1'b0;
      if (count == 2'd1 && close) begin
        hit = 1'b1;
        count_next = '0;
        tap_time_next = '0;
        tap_x_next = '0;
        tap_y_next = '0;
        armed_next = 1'b1;
      end else begin
        // first tap, or restart from this tap
        count_next = 2'd1;
        tap_time_next = now;
        tap_x_next = x;
        tap_y_next = y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      tap_time <= '0;
      tap_x <= '0;
      tap_y <= '0;
      armed <= 1'b1;
      rel_seen <= 1'b1;
    end else if (ctl.step) begin
      count <= count_next;
      tap_time <= tap_time_next;
      tap_x <= tap_x_next;
      tap_y <= tap_y_next;
      armed <= armed_next;
      rel_seen <= rel_seen_next;
    end
  end

endmodule

// ===== sv/touch_wake_gesture_detector.sv =====
// ----------------------------------------------------------------------------
// touch_wake_gesture_detector
// Sweep and double tap wake gesture detection on a multitouch event stream.
// ----------------------------------------------------------------------------
// Takes one touch event per clock cycle while in_stall is low. Each accepted
// event yields exactly one result: the accepting edge loads the input
// register, and the edge on which the input register fires moves it through
// the tracker logic into the result register. The tracker state updates in
// the same cycle the result is registered, so consecutive events never wait
// on each other. Stall on the output holds the result register and then the
// input register.
module touch_wake_gesture_detector import twg_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1080,
  parameter int SCREEN_HEIGHT = 1920,
  parameter int EDGE_MARGIN   = 90
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  coord_t      event_value,
  input  logic [31:0] now_ms,
  input  logic        screen_off,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  horizontal_gesture,
  output logic [1:0]  vertical_gesture,
  output logic        double_tap
);

  localparam coord_t BOTTOM_EDGE = 16'(SCREEN_HEIGHT - EDGE_MARGIN);

  // configuration
  logic        en_double_tap, en_right, en_left, en_up, en_down;
  logic [15:0] swipe_timeout, tap_window;
  logic [11:0] tap_radius;

  // input register
  logic        in_full;
  logic [2:0]  in_func;
  coord_t      in_value;
  logic [31:0] in_now;
  logic        in_off;

  // position state
  coord_t      cur_x, cur_y;
  logic        x_seen, y_seen;

  logic signed [16:0] shifted;
  coord_t      adj_value;
  logic        fire, accept;
  logic        is_slot, is_release, is_pos, xs, ys, trig, edge_clear;
  coord_t      px, py;
  swipe_ctl_t  h_ctl, v_ctl;
  tap_ctl_t    t_ctl;
  hgest_t      h_res;
  vgest_t      v_res;
  logic        t_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      en_double_tap <= 1'b0;
      en_right <= 1'b0;
      en_left <= 1'b0;
      en_up <= 1'b0;
      en_down <= 1'b0;
      swipe_timeout <= SWIPE_TIMEOUT_RST;
      tap_window <= TAP_WINDOW_RST;
      tap_radius <= TAP_RADIUS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_EN_DOUBLE_TAP: en_double_tap <= wr_data[0];
        REG_EN_RIGHT:      en_right <= wr_data[0];
        REG_EN_LEFT:       en_left <= wr_data[0];
        REG_EN_UP:         en_up <= wr_data[0];
        REG_EN_DOWN:       en_down <= wr_data[0];
        REG_SWIPE_TIMEOUT: swipe_timeout <= wr_data;
        REG_TAP_WINDOW:    tap_window <= wr_data;
        REG_TAP_RADIUS:    tap_radius <= wr_data[11:0];
      endcase
    end
  end

  // screen-off X shift, saturating at the bottom of the range
  always_comb begin
    shifted = {event_value[15], event_value} - 17'(OFF_X_SHIFT);
    adj_value = event_value;
    if (screen_off && func == FN_POS_X) begin
      adj_value = (shifted < -17'sd32768) ? -16'sd32768 : shifted[15:0];
    end
  end

  assign fire     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= accept || in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_func <= func;
      in_value <= adj_value;
      in_now <= now_ms;
      in_off <= screen_off;
    end
  end

  always_comb begin
    is_slot = in_func == FN_SLOT;
    is_release = in_func == FN_TRACK_ID && in_value == -16'sd1;
    is_pos = !is_slot && !is_release;
    px = (is_pos && in_func == FN_POS_X) ? in_value : cur_x;
    py = (is_pos && in_func == FN_POS_Y) ? in_value : cur_y;
    xs = x_seen || (is_pos && in_func == FN_POS_X);
    ys = y_seen || (is_pos && in_func == FN_POS_Y);
    trig = is_pos && ((xs && ys) || (!in_off && xs && !ys));
    edge_clear = trig && !in_off && py < BOTTOM_EDGE;

    h_ctl.step = fire;
    h_ctl.clear = is_slot || is_release || edge_clear;
    h_ctl.eval = trig && !edge_clear;
    h_ctl.off = in_off;

    v_ctl.step = fire;
    v_ctl.clear = h_ctl.clear;
    v_ctl.eval = trig && in_off;
    v_ctl.off = in_off;

    t_ctl.step = fire;
    t_ctl.clear = is_slot;
    t_ctl.lift = is_release;
    t_ctl.check = is_release && in_off && en_double_tap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
      x_seen <= 1'b0;
      y_seen <= 1'b0;
    end else if (fire) begin
      cur_x <= px;
      cur_y <= py;
      x_seen <= xs && !trig;
      y_seen <= ys && !trig;
    end
  end

  twg_horiz #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_horiz (
    .clk      (clk),
    .rst      (rst),
    .ctl      (h_ctl),
    .x        (px),
    .now      (in_now),
    .en_right (en_right),
    .en_left  (en_left),
    .timeout  (swipe_timeout),
    .res      (h_res)
  );

  twg_vert u_vert (
    .clk     (clk),
    .rst     (rst),
    .ctl     (v_ctl),
    .y       (py),
    .now     (in_now),
    .en_up   (en_up),
    .en_down (en_down),
    .timeout (swipe_timeout),
    .res     (v_res)
  );

  twg_tap #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .EDGE_MARGIN   (EDGE_MARGIN)
  ) u_tap (
    .clk    (clk),
    .rst    (rst),
    .ctl    (t_ctl),
    .x      (cur_x),
    .y      (cur_y),
    .now    (in_now),
    .window (tap_window),
    .radius (tap_radius),
    .hit    (t_hit)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      horizontal_gesture <= h_res;
      vertical_gesture <= v_res;
      double_tap <= t_hit;
    end
  end

endmodule

// ===== sv/twg_checker.sv =====
// ----------------------------------------------------------------------------
// twg_checker
// Port-level checks of the touch wake gesture detector, bound to the top.
// ----------------------------------------------------------------------------
module twg_checker import twg_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        wr_en,
  input logic [2:0]  wr_index,
  input logic [15:0] wr_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  func,
  input coord_t      event_value,
  input logic [31:0] now_ms,
  input logic        screen_off,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  horizontal_gesture,
  input logic [1:0]  vertical_gesture,
  input logic        double_tap
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(horizontal_gesture) &&
      $stable(vertical_gesture) && $stable(double_tap))
    else $error("stalled result changed");

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled without a stalled result");

  // a release never reports a swipe
  a_tap_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && double_tap |-> horizontal_gesture == HG_NONE &&
      vertical_gesture == VG_NONE)
    else $error("double tap reported together with a swipe");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind touch_wake_gesture_detector twg_checker u_twg_checker (.*);

// ===== sim/twg_gesture_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twg_gesture_checker
// Watches both channels of the touch wake gesture detector and checks results.
// ----------------------------------------------------------------------------
// Tracks the register writes, runs its own gesture trackers on every accepted
// request and queues the expected result. Each accepted result is compared
// field by field with the oldest queued one. The mismatch count and the number
// of outstanding results go back to the test top.
module twg_gesture_checker import twg_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1080,
  parameter int SCREEN_HEIGHT = 1920,
  parameter int EDGE_MARGIN   = 90
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  func,
  input  coord_t      event_value,
  input  logic [31:0] now_ms,
  input  logic        screen_off,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  horizontal_gesture,
  input  logic [1:0]  vertical_gesture,
  input  logic        double_tap,
  output int          mismatches,
  output int          pending_results
);

  typedef struct {
    hgest_t h;
    vgest_t v;
    logic   dt;
  } gesture_t;

  logic        en_tap, en_right, en_left, en_up, en_down;
  logic [15:0] swipe_timeout, tap_window;
  logic [11:0] tap_radius;

  int          cur_x, cur_y, start_x, start_y, tap_x, tap_y;
  logic        x_seen, y_seen, horiz_armed, vert_armed, tap_armed, release_seen;
  logic [1:0]  horiz_bands, vert_bands, tap_count;
  logic [31:0] start_x_time, start_y_time, tap_time;

  gesture_t    expected_q[$];
  gesture_t    want;

  function void clear_swipe();
    horiz_armed  = 1'b1;
    horiz_bands  = 2'b00;
    start_x      = 0;
    start_x_time = '0;
    vert_armed   = 1'b1;
    vert_bands   = 2'b00;
    start_y      = 0;
    start_y_time = '0;
  endfunction

  function void clear_tap();
    tap_armed = 1'b1;
    tap_count = 2'd0;
    tap_time  = '0;
    tap_x     = 0;
    tap_y     = 0;
  endfunction

  function void start_tap(input int x, input int y, input logic [31:0] t);
    tap_time  = t;
    tap_x     = x;
    tap_y     = y;
    tap_count = tap_count + 2'd1;
  endfunction

  function automatic gesture_t predict_gesture(input logic [2:0] f, input coord_t raw,
                                               input logic [31:0] t, input logic off);
    gesture_t    g;
    int          value, s, dx, dy;
    logic        timely;
    logic [31:0] elapsed;
    g.h = HG_NONE;
    g.v = VG_NONE;
    g.dt = 1'b0;
    value = raw;
    if (off && f == FN_POS_X) begin
      value = value - OFF_X_SHIFT;
      if (value < -32768) value = -32768;
    end
    if (f == FN_SLOT) begin
      clear_swipe();
      clear_tap();
    end else if (f == FN_TRACK_ID && value == -1) begin
      clear_swipe();
      release_seen = 1'b1;
      if (off && en_tap && tap_armed && release_seen &&
          cur_x >= EDGE_MARGIN && cur_x <= SCREEN_WIDTH - EDGE_MARGIN &&
          cur_y >= EDGE_MARGIN && cur_y <= SCREEN_HEIGHT - EDGE_MARGIN) begin
        release_seen = 1'b0;
        dx = cur_x - tap_x;
        dy = cur_y - tap_y;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        elapsed = t - tap_time;
        if (tap_count == 2'd0) begin
          start_tap(cur_x, cur_y, t);
        end else if (tap_count == 2'd1 && dx < int'(tap_radius) &&
                     dy < int'(tap_radius) && elapsed < tap_window) begin
          tap_count = 2'd2;
        end else begin
          clear_tap();
          start_tap(cur_x, cur_y, t);
        end
        if (tap_count > 2'd1) begin
          clear_tap();
          g.dt = 1'b1;
        end
      end
    end else begin
      if (f == FN_POS_X) begin
        cur_x = value;
        x_seen = 1'b1;
      end
      if (f == FN_POS_Y) begin
        cur_y = value;
        y_seen = 1'b1;
      end
      if ((x_seen && y_seen) || (!off && x_seen && !y_seen)) begin
        x_seen = 1'b0;
        y_seen = 1'b0;
        // horizontal tracker
        if (!off && cur_y < SCREEN_HEIGHT - EDGE_MARGIN) begin
          clear_swipe();
        end else begin
          if (start_x == 0) begin
            start_x = cur_x;
            start_x_time = t;
          end
          elapsed = t - start_x_time;
          timely = elapsed < swipe_timeout;
          if (start_x < HORIZ_SPLIT && off && en_right) begin
            if (horiz_bands[0] || (cur_x > 0 && cur_x < BAND_1)) begin
              horiz_bands[0] = 1'b1;
              if (horiz_bands[1] || (cur_x > BAND_1 && cur_x < BAND_2)) begin
                horiz_bands[1] = 1'b1;
                if (cur_x > BAND_2 && cur_x > SCREEN_WIDTH - FINAL_GAP &&
                    horiz_armed && timely) begin
                  g.h = HG_RIGHT;
                  horiz_armed = 1'b0;
                end
              end
            end
          end else if (start_x >= HORIZ_SPLIT && off && en_left) begin
            if (horiz_bands[0] || (cur_x < SCREEN_WIDTH - FINAL_GAP && cur_x > BAND_2)) begin
              horiz_bands[0] = 1'b1;
              if (horiz_bands[1] || (cur_x < BAND_2 && cur_x > BAND_1)) begin
                horiz_bands[1] = 1'b1;
                if (cur_x < BAND_1 && cur_x < FINAL_GAP && horiz_armed && timely) begin
                  g.h = HG_LEFT;
                  horiz_armed = 1'b0;
                end
              end
            end
          end
        end
        // vertical tracker, screen off only
        if (off) begin
          if (start_y == 0) begin
            start_y = cur_y;
            start_y_time = t;
          end
          elapsed = t - start_y_time;
          timely = elapsed < swipe_timeout;
          s = start_y;
          if (s > VERT_SPLIT && en_up) begin
            if (vert_bands[0] || (cur_y < s && cur_y > s - VERT_STEP)) begin
              vert_bands[0] = 1'b1;
              if (vert_bands[1] || (cur_y < s - VERT_STEP && cur_y > s - 2 * VERT_STEP)) begin
                vert_bands[1] = 1'b1;
                if (cur_y < s - 3 * VERT_STEP && vert_armed && timely) begin
                  g.v = VG_UP;
                  vert_armed = 1'b0;
                end
              end
            end
          end else if (s <= VERT_SPLIT && en_down) begin
            if (vert_bands[0] || (cur_y > s && cur_y < s + VERT_STEP)) begin
              vert_bands[0] = 1'b1;
              if (vert_bands[1] || (cur_y > s + VERT_STEP && cur_y < s + 2 * VERT_STEP)) begin
                vert_bands[1] = 1'b1;
                if (cur_y > s + 3 * VERT_STEP && vert_armed && timely) begin
                  g.v = VG_DOWN;
                  vert_armed = 1'b0;
                end
              end
            end
          end
        end
      end
    end
    return g;
  endfunction

  initial begin
    mismatches = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      en_tap = 1'b0;
      en_right = 1'b0;
      en_left = 1'b0;
      en_up = 1'b0;
      en_down = 1'b0;
      swipe_timeout = SWIPE_TIMEOUT_RST;
      tap_window = TAP_WINDOW_RST;
      tap_radius = TAP_RADIUS_RST;
      cur_x = 0;
      cur_y = 0;
      x_seen = 1'b0;
      y_seen = 1'b0;
      clear_swipe();
      clear_tap();
      release_seen = 1'b1;
      expected_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_EN_DOUBLE_TAP: en_tap = wr_data[0];
          REG_EN_RIGHT:      en_right = wr_data[0];
          REG_EN_LEFT:       en_left = wr_data[0];
          REG_EN_UP:         en_up = wr_data[0];
          REG_EN_DOWN:       en_down = wr_data[0];
          REG_SWIPE_TIMEOUT: swipe_timeout = wr_data;
          REG_TAP_WINDOW:    tap_window = wr_data;
          REG_TAP_RADIUS:    tap_radius = wr_data[11:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("time %0t: result with no request outstanding (h %0d v %0d tap %0d)",
                   $time, horizontal_gesture, vertical_gesture, double_tap);
        end else begin
          want = expected_q.pop_front();
          if (horizontal_gesture !== want.h) begin
            mismatches++;
            $display("time %0t: horizontal_gesture expected %0d, got %0d",
                     $time, want.h, horizontal_gesture);
          end
          if (vertical_gesture !== want.v) begin
            mismatches++;
            $display("time %0t: vertical_gesture expected %0d, got %0d",
                     $time, want.v, vertical_gesture);
          end
          if (double_tap !== want.dt) begin
            mismatches++;
            $display("time %0t: double_tap expected %0d, got %0d",
                     $time, want.dt, double_tap);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_gesture(func, event_value, now_ms, screen_off));
    end
    pending_results = expected_q.size();
  end

endmodule

// ===== sim/touch_wake_gesture_detector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_wake_gesture_detector_test
// Stimulus and verdict for the touch wake gesture detector.
// ----------------------------------------------------------------------------
// A short directed run covers the event kinds, value and time extremes, X
// saturation, an unset start, a right swipe, an up swipe and a double tap.
// Random phases then replay swipes, double taps, broken touches and noise
// under several register settings, with random idle and stall on both sides,
// a stretch with none, and one long output hold-off. The checker module
// predicts and compares every result.
module touch_wake_gesture_detector_test;
  import twg_pkg::*;

  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES      = 7;
  localparam int HOLD_OFF_CYCLES = 100;
  localparam int WATCHDOG_LIMIT  = 5000;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [15:0] wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  func;
  coord_t      event_value;
  logic [31:0] now_ms;
  logic        screen_off;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  horizontal_gesture;
  logic [1:0]  vertical_gesture;
  logic        double_tap;
  int          mismatches;
  int          pending_results;

  logic [31:0] ms_now;
  int          ms_step_max;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  bit          hold_off;
  int          items_sent;
  int          quiet_cycles;

  touch_wake_gesture_detector dut (.*);

  twg_gesture_checker gesture_check (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("touch_wake_gesture_detector_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  task automatic send_event(input func_t f, input int value, input logic off);
    int v;
    v = value;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    ms_now = ms_now + $urandom_range(0, ms_step_max);
    in_valid    <= 1'b1;
    func        <= f;
    event_value <= v[15:0];
    now_ms      <= ms_now;
    screen_off  <= off;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_point(input int x, input int y, input logic off);
    int raw_x;
    raw_x = off ? x + OFF_X_SHIFT : x;
    if ($urandom_range(1)) begin
      send_event(FN_POS_X, raw_x, off);
      send_event(FN_POS_Y, y, off);
    end else begin
      send_event(FN_POS_Y, y, off);
      send_event(FN_POS_X, raw_x, off);
    end
  endtask

  task automatic program_settings(input logic [4:0] enables, input logic [15:0] timeout,
                                  input logic [15:0] window, input logic [11:0] radius);
    for (int i = 0; i < 8; i++) begin
      wr_en    <= 1'b1;
      wr_index <= i[2:0];
      case (i[2:0])
        REG_EN_DOUBLE_TAP: wr_data <= 16'(enables[0]);
        REG_EN_RIGHT:      wr_data <= 16'(enables[1]);
        REG_EN_LEFT:       wr_data <= 16'(enables[2]);
        REG_EN_UP:         wr_data <= 16'(enables[3]);
        REG_EN_DOWN:       wr_data <= 16'(enables[4]);
        REG_SWIPE_TIMEOUT: wr_data <= timeout;
        REG_TAP_WINDOW:    wr_data <= window;
        default:           wr_data <= 16'(radius);
      endcase
      @(negedge clk);
    end
    wr_en <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_gesture();
    int     kind, x, y, s, n;
    logic   off;
    coord_t noise_v;
    func_t  f;
    off = ($urandom_range(99) < 88);
    case ($urandom_range(3))
      0: ms_step_max = 5;
      1: ms_step_max = 40;
      2: ms_step_max = 150;
      default: ms_step_max = 600;
    endcase
    if ($urandom_range(19) == 0) ms_now = ms_now + $urandom();
    if ($urandom_range(1)) send_event(FN_SLOT, $urandom_range(9), off);
    y = $urandom_range(1919);
    kind = $urandom_range(9);
    case (kind)
      0: begin  // left to right
        send_point($urandom_range(1, 339), y, off);
        if ($urandom_range(1)) send_point($urandom_range(1, 339), y, off);
        send_point($urandom_range(341, 619), y, off);
        send_point($urandom_range(811, 1100), y, off);
      end
      1: begin  // right to left
        send_point($urandom_range(621, 809), y, off);
        send_point($urandom_range(341, 619), y, off);
        if ($urandom_range(1)) send_point($urandom_range(341, 619), y, off);
        send_point(int'($urandom_range(300)) - 30, y, off);
      end
      2: begin  // upward
        x = $urandom_range(1079);
        s = $urandom_range(801, 1919);
        send_point(x, s, off);
        send_point(x, s - int'($urandom_range(1, 134)), off);
        send_point(x, s - int'($urandom_range(136, 269)), off);
        send_point(x, s - int'($urandom_range(406, 800)), off);
      end
      3: begin  // downward
        x = $urandom_range(1079);
        s = $urandom_range(1, 800);
        send_point(x, s, off);
        send_point(x, s + int'($urandom_range(1, 134)), off);
        send_point(x, s + int'($urandom_range(136, 269)), off);
        send_point(x, s + int'($urandom_range(406, 800)), off);
      end
      4: begin  // diagonal, right and down together
        s = $urandom_range(1, 500);
        send_point($urandom_range(1, 339), s, off);
        send_point($urandom_range(341, 619), s + int'($urandom_range(1, 134)), off);
        send_point($urandom_range(811, 1100), s + int'($urandom_range(136, 269)), off);
        send_point($urandom_range(811, 1100), s + int'($urandom_range(406, 700)), off);
      end
      5, 6: begin  // double tap, sometimes near the edge margin
        if ($urandom_range(1)) begin
          x = $urandom_range(90, 990);
          y = $urandom_range(90, 1830);
        end else begin
          x = $urandom_range(60, 1020);
          y = $urandom_range(60, 1860);
        end
        send_point(x, y, off);
        send_event(FN_TRACK_ID, -1, off);
        ms_now = ms_now + $urandom_range(700);
        send_point(x + int'($urandom_range(400)) - 200, y + int'($urandom_range(400)) - 200, off);
        send_event(FN_TRACK_ID, -1, off);
      end
      7: begin  // swipe cut short
        send_point($urandom_range(1, 339), y, off);
        if ($urandom_range(1)) send_point($urandom_range(341, 619), y, off);
        case ($urandom_range(2))
          0: send_event(FN_SLOT, 0, off);
          1: send_point($urandom_range(811, 1100), y, !off);
          default: send_event(FN_TRACK_ID, $urandom_range(100), off);
        endcase
      end
      default: begin  // noise
        n = $urandom_range(1, 4);
        repeat (n) begin
          f = func_t'($urandom_range(4));
          noise_v = 16'($urandom());
          case ($urandom_range(7))
            0: noise_v = '0;
            1: noise_v = 16'(OFF_X_SHIFT);
            2: noise_v = -16'sd1;
            3: noise_v = 16'sh7FFF;
            4: noise_v = 16'sh8000;
            default: ;
          endcase
          send_event(f, noise_v, 1'($urandom_range(1)));
        end
      end
    endcase
    if ($urandom_range(99) < 70) send_event(FN_TRACK_ID, -1, off);
  endtask

  initial begin
    int phase_end;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_valid = 1'b0;
    func = FN_OTHER;
    event_value = '0;
    now_ms = '0;
    screen_off = 1'b0;
    ms_now = '0;
    ms_step_max = 10;
    sender_idle_pct = 35;
    receiver_stall_pct = 35;
    hold_off = 1'b0;
    items_sent = 0;
    quiet_cycles = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    program_settings(5'b11111, SWIPE_TIMEOUT_RST, TAP_WINDOW_RST, TAP_RADIUS_RST);
    ms_step_max = 0;
    send_event(FN_OTHER, 32767, 1'b0);
    ms_now = '1;
    send_event(FN_OTHER, -32768, 1'b1);
    ms_step_max = 10;
    send_event(FN_POS_X, -32768, 1'b1);
    send_event(FN_TRACK_ID, 7, 1'b1);
    send_event(FN_SLOT, 0, 1'b1);
    send_point(0, 1000, 1'b1);
    send_point(100, 1000, 1'b1);
    send_point(450, 1000, 1'b1);
    send_point(900, 1000, 1'b1);
    send_event(FN_TRACK_ID, -1, 1'b1);
    send_point(905, 1010, 1'b1);
    send_event(FN_TRACK_ID, -1, 1'b1);
    send_event(FN_POS_X, 500, 1'b0);
    send_point(500, 1500, 1'b1);
    send_point(500, 1450, 1'b1);
    send_point(500, 1300, 1'b1);
    send_point(500, 1000, 1'b1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      sender_idle_pct = 35;
      receiver_stall_pct = 35;
      ms_now = $urandom();
      case (phase)
        0: program_settings(5'b11111, SWIPE_TIMEOUT_RST, TAP_WINDOW_RST, TAP_RADIUS_RST);
        1: begin
          program_settings(5'b11111, 16'hFFFF, 16'hFFFF, 12'hFFF);
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          hold_off = 1'b1;
        end
        2: program_settings(5'b11111, 16'd0, 16'd0, 12'd0);
        3: program_settings(5'($urandom()), 16'($urandom_range(50, 1000)),
                            16'($urandom_range(50, 1000)), 12'($urandom_range(400)));
        4: program_settings(5'b00000, 16'($urandom()), 16'($urandom()), 12'($urandom()));
        5: program_settings(5'b11111, 16'($urandom_range(20, 2000)),
                            16'($urandom_range(20, 2000)), 12'($urandom_range(50, 300)));
        default: begin
          program_settings(5'($urandom()), 16'($urandom_range(100, 700)),
                           16'($urandom_range(100, 700)), 12'($urandom_range(400)));
          ms_now = 32'hFFFF_F000;
        end
      endcase
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) run_gesture();
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("touch_wake_gesture_detector_test: PASS");
    end else begin
      $display("touch_wake_gesture_detector_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== touch_wake_gesture_detector.f =====
sv/twg_pkg.sv
sv/twg_horiz.sv
sv/twg_vert.sv
sv/twg_tap.sv
sv/touch_wake_gesture_detector.sv
sv/twg_checker.sv
sim/twg_gesture_checker.sv
sim/touch_wake_gesture_detector_test.sv
